>>> rtl/vmt_pkg.sv
// Shared types and constants for the vertex matrix transform block.
// No dependencies; compiled first.
package vmt_pkg;

  // Port field widths fixed by the channel definition
  localparam int unsigned FIELD_W    = 32;
  localparam int unsigned HALF_W     = 32;
  localparam int unsigned CFG_DATA_W = 64;
  localparam int unsigned CFG_IDX_W  = 8;
  localparam int unsigned NUM_REGS   = 8;
  localparam int unsigned REG_IDX_W  = 3;

  // Vertex request payload
  typedef struct packed {
    logic signed [FIELD_W-1:0] vec_x;
    logic signed [FIELD_W-1:0] vec_y;
    logic signed [FIELD_W-1:0] vec_z;
    logic signed [FIELD_W-1:0] vec_w;
  } vtx_in_t;

  // Transformed vertex payload
  typedef struct packed {
    logic signed [FIELD_W-1:0] out_x;
    logic signed [FIELD_W-1:0] out_y;
    logic signed [FIELD_W-1:0] out_z;
    logic signed [FIELD_W-1:0] out_w;
    logic                      clipped;
  } vtx_out_t;

endpackage

>>> rtl/vmt_if.sv
// Valid/ready channel interfaces for vertex requests and results.
// Depends on vmt_pkg.
interface vmt_in_if;
  import vmt_pkg::*;
  logic    valid;
  logic    ready;
  vtx_in_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface vmt_out_if;
  import vmt_pkg::*;
  logic     valid;
  logic     ready;
  vtx_out_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

>>> rtl/vertex_matrix_transform.sv
// Vertex matrix transform: 4x4 fixed-point matrix times homogeneous vertex.
// Depends on vmt_pkg and the channel interfaces in vmt_if.sv.
//
// Usage:
//  - in_i carries one vertex (x, y, z, w) per request; out_o returns the
//    transformed vertex plus a clipped flag, one result per request, in order.
//  - The matrix sits in eight 64-bit registers written through cfg_we_i /
//    cfg_idx_i / cfg_data_i; index 2r holds row r columns 0 and 1, index 2r+1
//    columns 2 and 3 (even column in the low half). Indexes above 7 are
//    ignored. Write only while no request is in flight.
//  - Results reach out_o through five register stages: input capture,
//    sixteen products, pairwise sums, row sums, shift and saturate.
//  - Throughput is one vertex per cycle unless out_o stalls; each stage
//    holds one request and the sixteen parallel multipliers in stage two
//    set the cycle time.
//  - Reset clears all stage valid bits and loads the identity matrix.
//  - When the receiver stalls, the result holds in the output register and
//    requests behind it close up into empty stages before in_i.ready drops.
module vertex_matrix_transform #(
  parameter int unsigned WORD_BITS = 32,
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [vmt_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [vmt_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  vmt_in_if.sink                           in_i,
  vmt_out_if.source                        out_o
);
  import vmt_pkg::*;

  localparam int unsigned PROD_W = 2 * WORD_BITS;
  localparam int unsigned PAIR_W = PROD_W + 1;
  localparam int unsigned SUM_W  = PROD_W + 2;
  localparam logic signed [SUM_W-1:0] MAXV =
    SUM_W'((65'(1) << (WORD_BITS - 1)) - 65'(1));
  localparam logic signed [SUM_W-1:0] MINV = -MAXV - SUM_W'(1);
  localparam logic [CFG_DATA_W-1:0] ONE = CFG_DATA_W'(1) << FRAC_BITS;

  // Identity reset value of one matrix register
  function automatic logic [CFG_DATA_W-1:0] cfg_reset(logic [REG_IDX_W-1:0] idx);
    logic [1:0] row;
    logic [CFG_DATA_W-1:0] val;
    row = idx[REG_IDX_W-1:1];
    val = '0;
    if (row[1] == idx[0]) begin
      val = row[0] ? (ONE << HALF_W) : ONE;
    end
    return val;
  endfunction

  // Matrix registers
  logic [CFG_DATA_W-1:0] cfg_q [NUM_REGS];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_REGS; i++) begin
        cfg_q[i] <= cfg_reset(REG_IDX_W'(i));
      end
    end else if (cfg_we_i && (cfg_idx_i < CFG_IDX_W'(NUM_REGS))) begin
      cfg_q[cfg_idx_i[REG_IDX_W-1:0]] <= cfg_data_i;
    end
  end

  // Matrix entries, low WORD_BITS of each half, signed
  logic signed [WORD_BITS-1:0] mat [4][4];

  always_comb begin
    for (int r = 0; r < 4; r++) begin
      for (int c = 0; c < 4; c++) begin
        mat[r][c] = cfg_q[2*r + (c >> 1)][(c & 1)*HALF_W +: WORD_BITS];
      end
    end
  end

  // Stage valid bits and per-stage ready chain
  logic s0_v_q, s1_v_q, s2_v_q, s3_v_q, out_v_q;
  logic rdy0, rdy1, rdy2, rdy3, rdy4;

  assign rdy4 = !out_v_q || out_o.ready;
  assign rdy3 = !s3_v_q  || rdy4;
  assign rdy2 = !s2_v_q  || rdy3;
  assign rdy1 = !s1_v_q  || rdy2;
  assign rdy0 = !s0_v_q  || rdy1;

  assign in_i.ready  = rdy0;
  assign out_o.valid = out_v_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_v_q  <= 1'b0;
      s1_v_q  <= 1'b0;
      s2_v_q  <= 1'b0;
      s3_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      if (rdy0) s0_v_q  <= in_i.valid;
      if (rdy1) s1_v_q  <= s0_v_q;
      if (rdy2) s2_v_q  <= s1_v_q;
      if (rdy3) s3_v_q  <= s2_v_q;
      if (rdy4) out_v_q <= s3_v_q;
    end
  end

  // Stage 0: capture vertex, keep low WORD_BITS
  logic signed [WORD_BITS-1:0] vec_q [4];

  always_ff @(posedge clk_i) begin
    if (rdy0 && in_i.valid) begin
      vec_q[0] <= in_i.data.vec_x[WORD_BITS-1:0];
      vec_q[1] <= in_i.data.vec_y[WORD_BITS-1:0];
      vec_q[2] <= in_i.data.vec_z[WORD_BITS-1:0];
      vec_q[3] <= in_i.data.vec_w[WORD_BITS-1:0];
    end
  end

  // Stage 1: sixteen products
  logic signed [PROD_W-1:0] prod_q [4][4];

  always_ff @(posedge clk_i) begin
    if (rdy1 && s0_v_q) begin
      for (int r = 0; r < 4; r++) begin
        for (int c = 0; c < 4; c++) begin
          prod_q[r][c] <= PROD_W'(mat[r][c]) * PROD_W'(vec_q[c]);
        end
      end
    end
  end

  // Stage 2: pairwise sums per row
  logic signed [PAIR_W-1:0] pair_q [4][2];

  always_ff @(posedge clk_i) begin
    if (rdy2 && s1_v_q) begin
      for (int r = 0; r < 4; r++) begin
        for (int p = 0; p < 2; p++) begin
          pair_q[r][p] <= PAIR_W'(prod_q[r][2*p]) + PAIR_W'(prod_q[r][2*p+1]);
        end
      end
    end
  end

  // Stage 3: full row sums
  logic signed [SUM_W-1:0] sum_q [4];

  always_ff @(posedge clk_i) begin
    if (rdy3 && s2_v_q) begin
      for (int r = 0; r < 4; r++) begin
        sum_q[r] <= SUM_W'(pair_q[r][0]) + SUM_W'(pair_q[r][1]);
      end
    end
  end

  // Stage 4: arithmetic shift (floor) and saturate
  logic signed [SUM_W-1:0]     shifted [4];
  logic signed [WORD_BITS-1:0] sat     [4];
  logic [3:0]                  clip;
  vtx_out_t                    res_d, res_q;

  always_comb begin
    for (int r = 0; r < 4; r++) begin
      shifted[r] = sum_q[r] >>> FRAC_BITS;
      clip[r]    = 1'b0;
      sat[r]     = shifted[r][WORD_BITS-1:0];
      if (shifted[r] > MAXV) begin
        sat[r]  = MAXV[WORD_BITS-1:0];
        clip[r] = 1'b1;
      end else if (shifted[r] < MINV) begin
        sat[r]  = MINV[WORD_BITS-1:0];
        clip[r] = 1'b1;
      end
    end
    res_d.out_x   = FIELD_W'(sat[0]);
    res_d.out_y   = FIELD_W'(sat[1]);
    res_d.out_z   = FIELD_W'(sat[2]);
    res_d.out_w   = FIELD_W'(sat[3]);
    res_d.clipped = |clip;
  end

  always_ff @(posedge clk_i) begin
    if (rdy4 && s3_v_q) begin
      res_q <= res_d;
    end
  end

  assign out_o.data = res_q;

endmodule

>>> rtl/vmt_checker.sv
// Port-level checks for the vertex matrix transform, bound to the top level.
// Depends on vmt_pkg and vertex_matrix_transform.
module vmt_checker #(
  parameter int unsigned WORD_BITS = 32
) (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              out_valid,
  input logic              out_ready,
  input vmt_pkg::vtx_out_t out_data
);
  import vmt_pkg::*;

  localparam logic signed [FIELD_W-1:0] MAXW =
    FIELD_W'((33'(1) << (WORD_BITS - 1)) - 33'(1));
  localparam logic signed [FIELD_W-1:0] MINW = -MAXW - FIELD_W'(1);

  // Component narrowed to the word and sign-extended back
  function automatic logic signed [FIELD_W-1:0] narrow(logic signed [FIELD_W-1:0] v);
    logic signed [WORD_BITS-1:0] w;
    w = v[WORD_BITS-1:0];
    return FIELD_W'(w);
  endfunction

  // Pipeline comes out of reset empty
  a_reset_empty: assert property (@(posedge clk_i) !rst_ni |=> !out_valid)
    else $error("result valid straight after reset");

  // A stalled result holds, valid and payload alike
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  // Clip flag only with some component at a saturation limit
  a_clip_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && out_data.clipped |->
      out_data.out_x == MAXW || out_data.out_x == MINW ||
      out_data.out_y == MAXW || out_data.out_y == MINW ||
      out_data.out_z == MAXW || out_data.out_z == MINW ||
      out_data.out_w == MAXW || out_data.out_w == MINW)
    else $error("clipped set with no component at a limit");

  // Components fit in the configured word width
  a_word_fit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |->
      out_data.out_x == narrow(out_data.out_x) &&
      out_data.out_y == narrow(out_data.out_y) &&
      out_data.out_z == narrow(out_data.out_z) &&
      out_data.out_w == narrow(out_data.out_w))
    else $error("result component not sign-extended from word width");

endmodule

bind vertex_matrix_transform vmt_checker #(.WORD_BITS(WORD_BITS)) u_vmt_checker (
  .clk_i     (clk_i),
  .rst_ni    (rst_ni),
  .out_valid (out_o.valid),
  .out_ready (out_o.ready),
  .out_data  (out_o.data)
);
